// ----- sv/tsg_pkg.sv -----
// Shared types, widths and codes for the 2-D t-SNE gradient block.
package tsg_pkg;

    localparam int PT_DEPTH  = 256;
    localparam int PT_AW     = $clog2(PT_DEPTH);
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ROW_W     = 8;
    localparam int PC_W      = 9;
    localparam int NORM_W    = 33;
    localparam int FON_W     = 40;
    localparam int PW_W      = 32;
    localparam int ACC_W     = 48;

    // Shared multiplier: 32 x 32 per cycle, operands of two digits.
    localparam int DIG_W     = 32;
    localparam int OPD_W     = 2 * DIG_W;
    localparam int PROD_W    = 2 * OPD_W;

    // Fixed-point shifts and magnitude widths along the chain.
    localparam int ZP_SH     = 16;
    localparam int M_SH      = 31;
    localparam int K_SH      = 32;
    localparam int T_SH      = 23;
    localparam int D_W       = 49;
    localparam int M_W       = 50;
    localparam int K_W       = 58;
    localparam int TERM_W    = 50;
    localparam logic [TERM_W-1:0] TERM_LIM = TERM_W'(1) << (TERM_W - 1);

    // Configuration port.
    localparam int CFG_W     = FON_W;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SUM       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_OVER_NORM = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PAIR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_I,
        S_RD_J,
        S_DIFF,
        S_GO,
        S_WAIT,
        S_ACC,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_ZP,
        OP_M,
        OP_K,
        OP_TX,
        OP_TY
    } mul_op_t;

    typedef struct packed {
        logic add;
        logic clear;
    } acc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// ----- sv/tsg_point_mem.sv -----
// Point coordinate table: one write port, one read port with registered data.
module tsg_point_mem (
    input  logic                              clk,
    input  logic                              we,
    input  logic [tsg_pkg::PT_AW-1:0]         waddr,
    input  logic [2*tsg_pkg::COORD_W-1:0]     wdata,
    input  logic [tsg_pkg::PT_AW-1:0]         raddr,
    output logic [2*tsg_pkg::COORD_W-1:0]     rdata
);
    import tsg_pkg::*;

    logic [2*COORD_W-1:0] mem [PT_DEPTH];
    logic [2*COORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tsg_mul_unit.sv -----
// Shared unsigned multiplier: 64 x 64 product built from four 32 x 32 partial products.
module tsg_mul_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tsg_pkg::OPD_W-1:0]     op_a,
    input  logic [tsg_pkg::OPD_W-1:0]     op_b,
    output tsg_pkg::mul_stat_t            stat,
    output logic [tsg_pkg::PROD_W-1:0]    product
);
    import tsg_pkg::*;

    logic [OPD_W-1:0]  a_reg;
    logic [OPD_W-1:0]  b_reg;
    logic [2:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [OPD_W-1:0]  pp_reg;
    logic [1:0]        pp_sh_reg;
    logic              pp_vld_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [DIG_W-1:0]  a_dig;
    logic [DIG_W-1:0]  b_dig;
    logic              issue;

    assign a_dig = step_reg[1] ? a_reg[OPD_W-1:DIG_W] : a_reg[DIG_W-1:0];
    assign b_dig = step_reg[0] ? b_reg[OPD_W-1:DIG_W] : b_reg[DIG_W-1:0];
    assign issue = busy_reg && !step_reg[2];

    // Control: four issue steps, and the run ends with the last accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= issue;
            done_reg   <= busy_reg && step_reg[2] && pp_vld_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (issue)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else if (busy_reg && pp_vld_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The partial product is registered before it is added in at its digit offset.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pp_reg    <= OPD_W'(a_dig) * OPD_W'(b_dig);
            pp_sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
        end
        if (start)
        begin
            a_reg    <= op_a;
            b_reg    <= op_b;
            prod_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            prod_reg <= prod_reg + (PROD_W'(pp_reg) << (pp_sh_reg * DIG_W));
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = prod_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("multiplier done without a finished run");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held for two cycles");

endmodule

// ----- sv/tsg_accum.sv -----
// Row accumulators: saturating signed Q24.24 sums with a sticky clip flag.
module tsg_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tsg_pkg::acc_ctrl_t                  ctrl,
    input  logic [tsg_pkg::TERM_W-1:0]          tx_mag,
    input  logic                                tx_neg,
    input  logic [tsg_pkg::TERM_W-1:0]          ty_mag,
    input  logic                                ty_neg,
    output logic signed [tsg_pkg::ACC_W-1:0]    acc_x,
    output logic signed [tsg_pkg::ACC_W-1:0]    acc_y,
    output logic                                clip
);
    import tsg_pkg::*;

    localparam int SUM_W = TERM_W + 2;

    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic                    clip_reg;
    logic [ACC_W:0]          res_x;
    logic [ACC_W:0]          res_y;

    // Returns the clip bit above the saturated sum. The negation of the
    // term folds into the adder as an inversion with a carry in.
    function automatic logic [ACC_W:0] sat_add(
        input logic [ACC_W-1:0]  acc,
        input logic [TERM_W-1:0] mag,
        input logic              neg
    );
        logic [SUM_W-1:0] sum;
        logic [ACC_W-1:0] res;
        logic             hit;
        sum = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc}
            + ({2'b00, mag} ^ {SUM_W{neg}})
            + {{(SUM_W-1){1'b0}}, neg};
        hit = 1'b0;
        res = sum[ACC_W-1:0];
        if (!sum[SUM_W-1] && (sum[SUM_W-2:ACC_W-1] != '0))
        begin
            hit = 1'b1;
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        else if (sum[SUM_W-1] && (sum[SUM_W-2:ACC_W-1] != '1))
        begin
            hit = 1'b1;
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end
        return {hit, res};
    endfunction

    assign res_x = sat_add(acc_x_reg, tx_mag, tx_neg);
    assign res_y = sat_add(acc_y_reg, ty_mag, ty_neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            clip_reg  <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            clip_reg  <= 1'b0;
        end
        else if (ctrl.add)
        begin
            acc_x_reg <= res_x[ACC_W-1:0];
            acc_y_reg <= res_y[ACC_W-1:0];
            clip_reg  <= clip_reg | res_x[ACC_W] | res_y[ACC_W];
        end
    end

    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;
    assign clip  = clip_reg;

endmodule

// ----- sv/tsne_gradient_2d.sv -----
// Exact t-SNE gradient for a 2-D embedding. A load item writes one point's
// coordinates into a 256-entry table; loads may follow each other in every
// cycle while no pair is in work. A pair item whose row and column differ
// passes S_RD_I and S_RD_J to read both points and S_DIFF to form the
// coordinate differences, then five products (Z*P, W*d, (4/Z)*m and k times
// each difference) on one shared 32 x 32 multiplier, each product taking four
// partial products, then S_ACC and S_FIN to accumulate and close. A diagonal
// pair goes straight to S_FIN. The block stalls its input while a pair is in
// work. At the last column the row's gradient goes into an output register;
// if the previous gradient has not yet been taken, the block waits there.
module tsne_gradient_2d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsg_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [tsg_pkg::ROW_W-1:0]           row,
    input  logic [tsg_pkg::ROW_W-1:0]           col,
    input  logic signed [tsg_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [tsg_pkg::COORD_W-1:0]  coord_y,
    input  logic [tsg_pkg::PW_W-1:0]            affinity,
    input  logic [tsg_pkg::PW_W-1:0]            kernel_weight,
    output logic                                grad_valid,
    input  logic                                grad_stall,
    output logic [tsg_pkg::ROW_W-1:0]           grad_row,
    output logic signed [tsg_pkg::ACC_W-1:0]    grad_x,
    output logic signed [tsg_pkg::ACC_W-1:0]    grad_y,
    output logic                                saturated
);
    import tsg_pkg::*;

    // Configuration registers.
    logic [PC_W-1:0]     point_count_reg;
    logic [NORM_W-1:0]   norm_sum_reg;
    logic [FON_W-1:0]    four_over_norm_reg;

    // Sequencer.
    state_t              state_reg;
    state_t              state_next;
    mul_op_t             op_reg;

    // Item and intermediate values.
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    col_reg;
    logic [PW_W-1:0]     p_reg;
    logic [PW_W-1:0]     w_reg;
    logic [COORD_W-1:0]  xi_reg;
    logic [COORD_W-1:0]  yi_reg;
    logic [DIFF_W-1:0]   dx_mag_reg;
    logic                dx_neg_reg;
    logic [DIFF_W-1:0]   dy_mag_reg;
    logic                dy_neg_reg;
    logic [D_W-1:0]      d_mag_reg;
    logic                d_neg_reg;
    logic [M_W-1:0]      m_mag_reg;
    logic [K_W-1:0]      k_mag_reg;
    logic [TERM_W-1:0]   tx_mag_reg;
    logic                tx_neg_reg;
    logic [TERM_W-1:0]   ty_mag_reg;
    logic                ty_neg_reg;

    // Output register.
    logic                grad_valid_reg;
    logic [ROW_W-1:0]    grad_row_reg;
    logic [ACC_W-1:0]    grad_x_reg;
    logic [ACC_W-1:0]    grad_y_reg;
    logic                sat_reg;

    logic                accept;
    logic                slot_free;
    logic                is_last;
    logic                emit;
    logic [ROW_W-1:0]    last_col;
    logic                mul_start;
    mul_stat_t           mul_stat;
    logic [OPD_W-1:0]    mul_a;
    logic [OPD_W-1:0]    mul_b;
    logic [PROD_W-1:0]   product;
    acc_ctrl_t           acc_ctrl;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic                clip;
    logic                mem_we;
    logic [PT_AW-1:0]    mem_raddr;
    logic [2*COORD_W-1:0] mem_rdata;
    logic [COORD_W-1:0]  xj;
    logic [COORD_W-1:0]  yj;
    logic [DIFF_W-1:0]   dx_fwd;
    logic [DIFF_W-1:0]   dx_rev;
    logic [DIFF_W-1:0]   dy_fwd;
    logic [DIFF_W-1:0]   dy_rev;
    logic [D_W-1:0]      zp;
    logic [D_W-1:0]      w_ext;
    logic [TERM_W-1:0]   term_mag;
    logic                term_big;

    assign accept    = item_valid && !item_stall;
    assign slot_free = !grad_valid_reg || !grad_stall;

    // A point count of zero acts as one, and counts above the table as the table.
    always_comb
    begin
        if (point_count_reg == '0)
        begin
            last_col = '0;
        end
        else if (point_count_reg > PC_W'(PT_DEPTH))
        begin
            last_col = '1;
        end
        else
        begin
            last_col = ROW_W'(point_count_reg - PC_W'(1));
        end
    end

    assign is_last = (col_reg == last_col);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg    <= PC_W'(1);
            norm_sum_reg       <= NORM_W'(65536);
            four_over_norm_reg <= FON_W'(64'd17179869184);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POINT_COUNT:    point_count_reg    <= cfg_data[PC_W-1:0];
                CFG_NORM_SUM:       norm_sum_reg       <= cfg_data[NORM_W-1:0];
                CFG_FOUR_OVER_NORM: four_over_norm_reg <= cfg_data[FON_W-1:0];
                default:            ;
            endcase
        end
    end

    // Point table.
    assign mem_we = accept && (command == CMD_LOAD);

    tsg_point_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (row),
        .wdata ({coord_y, coord_x}),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign xj = mem_rdata[COORD_W-1:0];
    assign yj = mem_rdata[2*COORD_W-1:COORD_W];

    // Both orders of the difference are formed, and the sign picks the magnitude.
    assign dx_fwd = {xi_reg[COORD_W-1], xi_reg} - {xj[COORD_W-1], xj};
    assign dx_rev = {xj[COORD_W-1], xj} - {xi_reg[COORD_W-1], xi_reg};
    assign dy_fwd = {yi_reg[COORD_W-1], yi_reg} - {yj[COORD_W-1], yj};
    assign dy_rev = {yj[COORD_W-1], yj} - {yi_reg[COORD_W-1], yi_reg};

    // Shared multiplier and its operand selection.
    always_comb
    begin
        case (op_reg)
            OP_ZP:
            begin
                mul_a = OPD_W'(norm_sum_reg);
                mul_b = OPD_W'(p_reg);
            end
            OP_M:
            begin
                mul_a = OPD_W'(w_reg);
                mul_b = OPD_W'(d_mag_reg);
            end
            OP_K:
            begin
                mul_a = OPD_W'(four_over_norm_reg);
                mul_b = OPD_W'(m_mag_reg);
            end
            OP_TX:
            begin
                mul_a = OPD_W'(k_mag_reg);
                mul_b = OPD_W'(dx_mag_reg);
            end
            OP_TY:
            begin
                mul_a = OPD_W'(k_mag_reg);
                mul_b = OPD_W'(dy_mag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tsg_mul_unit u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .stat    (mul_stat),
        .product (product)
    );

    assign zp    = product[ZP_SH +: D_W];
    assign w_ext = D_W'(w_reg);

    // A term above 2^49 in magnitude is held at 2^49; the accumulator then clips.
    assign term_big = (product[PROD_W-1:T_SH+TERM_W] != '0)
                   || (product[T_SH +: TERM_W] > TERM_LIM);
    assign term_mag = term_big ? TERM_LIM : product[T_SH +: TERM_W];

    tsg_accum u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .tx_mag (tx_mag_reg),
        .tx_neg (tx_neg_reg),
        .ty_mag (ty_mag_reg),
        .ty_neg (ty_neg_reg),
        .acc_x  (acc_x),
        .acc_y  (acc_y),
        .clip   (clip)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == CMD_PAIR))
                begin
                    state_next = (row == col) ? S_FIN : S_RD_I;
                end
            end
            S_RD_I: state_next = S_RD_J;
            S_RD_J: state_next = S_DIFF;
            S_DIFF: state_next = S_GO;
            S_GO:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (mul_stat.done)
                begin
                    state_next = (op_reg == OP_TY) ? S_ACC : S_GO;
                end
            end
            S_ACC:  state_next = S_FIN;
            S_FIN:
            begin
                if (!is_last || slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        item_stall     = (state_reg != S_IDLE);
        mul_start      = (state_reg == S_GO);
        mem_raddr      = (state_reg == S_RD_I) ? row_reg : col_reg;
        emit           = (state_reg == S_FIN) && is_last && slot_free;
        acc_ctrl.add   = (state_reg == S_ACC);
        acc_ctrl.clear = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ZP;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIFF)
            begin
                op_reg <= OP_ZP;
            end
            else if ((state_reg == S_WAIT) && mul_stat.done)
            begin
                case (op_reg)
                    OP_ZP:   op_reg <= OP_M;
                    OP_M:    op_reg <= OP_K;
                    OP_K:    op_reg <= OP_TX;
                    OP_TX:   op_reg <= OP_TY;
                    default: op_reg <= OP_ZP;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= row;
            col_reg <= col;
            p_reg   <= affinity;
            w_reg   <= kernel_weight;
        end
        if (state_reg == S_RD_J)
        begin
            xi_reg <= mem_rdata[COORD_W-1:0];
            yi_reg <= mem_rdata[2*COORD_W-1:COORD_W];
        end
        if (state_reg == S_DIFF)
        begin
            dx_neg_reg <= dx_fwd[DIFF_W-1];
            dx_mag_reg <= dx_fwd[DIFF_W-1] ? dx_rev : dx_fwd;
            dy_neg_reg <= dy_fwd[DIFF_W-1];
            dy_mag_reg <= dy_fwd[DIFF_W-1] ? dy_rev : dy_fwd;
        end
        if ((state_reg == S_WAIT) && mul_stat.done)
        begin
            // The signs of m and k follow d, since W and 4/Z are never negative.
            case (op_reg)
                OP_ZP:
                begin
                    d_neg_reg <= (zp < w_ext);
                    d_mag_reg <= (zp < w_ext) ? (w_ext - zp) : (zp - w_ext);
                end
                OP_M:    m_mag_reg <= product[M_SH +: M_W];
                OP_K:    k_mag_reg <= product[K_SH +: K_W];
                OP_TX:
                begin
                    tx_mag_reg <= term_mag;
                    tx_neg_reg <= d_neg_reg ^ dx_neg_reg;
                end
                OP_TY:
                begin
                    ty_mag_reg <= term_mag;
                    ty_neg_reg <= d_neg_reg ^ dy_neg_reg;
                end
                default: ;
            endcase
        end
        if (emit)
        begin
            grad_row_reg <= row_reg;
            grad_x_reg   <= acc_x;
            grad_y_reg   <= acc_y;
            sat_reg      <= clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grad_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            grad_valid_reg <= 1'b1;
        end
        else if (!grad_stall)
        begin
            grad_valid_reg <= 1'b0;
        end
    end

    assign grad_valid = grad_valid_reg;
    assign grad_row   = grad_row_reg;
    assign grad_x     = grad_x_reg;
    assign grad_y     = grad_y_reg;
    assign saturated  = sat_reg;

    a_load_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == CMD_LOAD) |=> $stable(acc_x) && $stable(acc_y))
        else $error("load beat changed the row accumulators");

    a_grad_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(grad_valid) |-> $past(state_reg == S_FIN) && $past(is_last))
        else $error("gradient beat raised outside the closing step");

    a_mul_only_when_working: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.busy |-> (state_reg == S_WAIT))
        else $error("multiplier running outside a product step");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (acc_x == '0) && (acc_y == '0) && !clip)
        else $error("accumulators not cleared after a gradient beat");

endmodule
